### src/sarcs_pkg.sv
// shared types and constants for the stick auto-repeat cursor stepper
// no dependencies; imported by sarcs_step and the top level
package sarcs_pkg;

    // operation codes carried in the op field
    typedef logic [2:0] t_op;
    localparam t_op OP_X_AXIS  = 3'd0;
    localparam t_op OP_Y_STD   = 3'd1;
    localparam t_op OP_Y_FAST  = 3'd2;
    localparam t_op OP_Y_EXTRA = 3'd3;
    localparam t_op OP_NONE    = 3'd4;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEAD_ZONE     = 2'd0;
    localparam t_cfg_idx CFG_REPEAT_DELAY  = 2'd1;
    localparam t_cfg_idx CFG_REPEAT_PERIOD = 2'd2;

    // register reset values
    localparam logic [6:0] DEAD_ZONE_RST     = 7'd12;
    localparam logic [6:0] REPEAT_DELAY_RST  = 7'd9;
    localparam logic [6:0] REPEAT_PERIOD_RST = 7'd2;

    // extra repeat rule fires again this many counts after the delay
    localparam logic [8:0] EXTRA_REPEAT_OFS  = 9'd3;

    typedef struct packed {
        t_op               op;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic [7:0]        cursor_in;
        logic [7:0]        cursor_max;
        logic              wrap;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cursor_out;
        logic [7:0] hold_count;
        logic       stepped;
    } t_out_item;

    typedef struct packed {
        logic [6:0] dead_zone;
        logic [6:0] repeat_delay;
        logic [6:0] repeat_period;
    } t_cfg;

    // state carried from one frame to the next
    typedef struct packed {
        logic [7:0]        hold_counter;
        logic signed [7:0] previous_x;
        logic signed [7:0] previous_y;
    } t_hist;

endpackage

### src/sarcs_step.sv
// combinational frame update: hold counter, fire decision and cursor step
// depends on sarcs_pkg
module sarcs_step
    import sarcs_pkg::*;
(
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_hist     i_hist,
    output t_hist     o_hist,
    output t_out_item o_result
);

    logic [7:0]        mag_x, mag_y, mag_px, mag_py, dz;
    logic signed [7:0] sx, sy, px, py;
    logic              defl, rev_x, rev_y;
    logic [8:0]        cnt_inc, cnt_pre, limit;
    logic [6:0]        dly;
    logic [7:0]        cnt;
    logic              fire, step_up, step_dn;
    logic signed [9:0] sum;
    logic              below, above;
    logic [7:0]        cur_fix;

    always_comb begin
        sx = i_item.stick_x;
        sy = i_item.stick_y;
        px = i_hist.previous_x;
        py = i_hist.previous_y;
        dz = {1'b0, i_cfg.dead_zone};

        // magnitudes as unsigned, so -128 gives 128
        mag_x  = sx[7] ? (~sx + 8'd1) : sx;
        mag_y  = sy[7] ? (~sy + 8'd1) : sy;
        mag_px = px[7] ? (~px + 8'd1) : px;
        mag_py = py[7] ? (~py + 8'd1) : py;

        defl  = (mag_x > dz) || (mag_y > dz);
        // sign reversal against a previous sample that was itself deflected
        rev_x = ((sx[7] && !px[7] && (px != 8'sd0)) || (!sx[7] && (sx != 8'sd0) && px[7]))
                && (mag_px > dz);
        rev_y = ((sy[7] && !py[7] && (py != 8'sd0)) || (!sy[7] && (sy != 8'sd0) && py[7]))
                && (mag_py > dz);

        dly     = (i_cfg.repeat_delay == 7'd0) ? 7'd1 : i_cfg.repeat_delay;
        limit   = {2'b0, dly} + {2'b0, i_cfg.repeat_period};
        cnt_inc = {1'b0, i_hist.hold_counter} + 9'd1;
        cnt_pre = (defl && !rev_x && !rev_y) ? cnt_inc : 9'd0;
        cnt     = (cnt_pre >= limit) ? {1'b0, dly - 7'd1} : cnt_pre[7:0];

        fire    = 1'b0;
        step_up = 1'b0;
        step_dn = 1'b0;
        case (i_item.op)
            OP_X_AXIS: begin
                fire    = (cnt == 8'd1) || (cnt == {1'b0, dly});
                step_up = !sx[7] && (mag_x > dz);
                step_dn = sx[7] && (mag_x > dz);
            end
            OP_Y_STD: begin
                fire    = (cnt == 8'd1) || (cnt == {1'b0, dly});
                step_dn = !sy[7] && (mag_y > dz);
                step_up = sy[7] && (mag_y > dz);
            end
            OP_Y_FAST: begin
                fire    = (cnt == 8'd1) || (cnt >= {1'b0, dly - 7'd1});
                step_dn = !sy[7] && (mag_y > dz);
                step_up = sy[7] && (mag_y > dz);
            end
            OP_Y_EXTRA: begin
                fire    = (cnt == 8'd1) || (cnt == {1'b0, dly})
                          || ({1'b0, cnt} == ({2'b0, dly} + EXTRA_REPEAT_OFS));
                step_dn = !sy[7] && (mag_y > dz);
                step_up = sy[7] && (mag_y > dz);
            end
            default: begin
                fire = 1'b0;
            end
        endcase

        sum = $signed({2'b0, i_item.cursor_in});
        if (step_up) begin
            sum = sum + 10'sd1;
        end else if (step_dn) begin
            sum = sum - 10'sd1;
        end
        below = sum < 10'sd0;
        above = sum > $signed({2'b0, i_item.cursor_max});

        // wrap or clamp into 0..cursor_max
        if (i_item.wrap) begin
            cur_fix = below ? i_item.cursor_max : (above ? 8'd0 : sum[7:0]);
        end else begin
            cur_fix = below ? 8'd0 : (above ? i_item.cursor_max : sum[7:0]);
        end

        o_hist.hold_counter   = cnt;
        o_hist.previous_x     = sx;
        o_hist.previous_y     = sy;
        o_result.cursor_out   = fire ? cur_fix : i_item.cursor_in;
        o_result.hold_count   = cnt;
        o_result.stepped      = fire;
    end

endmodule

### src/stick_auto_repeat_cursor_stepper_unit.sv
// top level of the stick auto-repeat cursor stepper
// depends on sarcs_pkg and sarcs_step
//
// usage
//   input channel: one frame per transfer (op, stick x/y, cursor, cursor max,
//   wrap) on i_in_data, qualified by i_in_valid, held off by o_in_stall
//   output channel: one result per frame (cursor_out, hold_count, stepped)
//   on o_out_data with o_out_valid, held off by i_out_stall
//   config channel: i_cfg_valid/o_cfg_ready with a register index and 7-bit
//   data; index 0 dead zone, 1 repeat delay, 2 repeat period, other indexes
//   are ignored; ready is always high, write only while the block is idle
// timing
//   two register stages: the frame is captured in an input register, the
//   counter/fire/step logic runs in one pass and lands in the result
//   register; one frame per cycle sustained while i_out_stall is low;
//   the hold counter and previous samples update in the same cycle the
//   frame moves to the result register
// reset
//   synchronous active low; registers return to 12/9/2, counter and
//   previous samples clear, both stages empty
// back pressure
//   with i_out_stall high the result holds; the input register still fills
//   once, then o_in_stall rises until the result drains
module stick_auto_repeat_cursor_stepper_unit
    import sarcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // frame input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    // config writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_idx   i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_hist     r_hist, n_hist;
    t_in_item  r_item;
    logic      r_item_valid;
    t_out_item r_res, n_res;
    logic      r_res_valid;
    logic      res_load;
    logic      item_load;

    // result register takes a new value when empty or being drained
    assign res_load  = r_item_valid && (!r_res_valid || !i_out_stall);
    // input register refills when empty or when its frame moves on
    assign item_load = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_item_valid && !res_load;
    assign o_out_valid = r_res_valid;
    assign o_out_data  = r_res;
    assign o_cfg_ready = 1'b1;

    sarcs_step u_step (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_hist   (r_hist),
        .o_hist   (n_hist),
        .o_result (n_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone     <= DEAD_ZONE_RST;
            r_cfg.repeat_delay  <= REPEAT_DELAY_RST;
            r_cfg.repeat_period <= REPEAT_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEAD_ZONE:     r_cfg.dead_zone     <= i_cfg_data;
                CFG_REPEAT_DELAY:  r_cfg.repeat_delay  <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_cfg.repeat_period <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // frame history advances only with a frame that reaches the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (res_load) begin
            r_hist <= n_hist;
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            if (item_load) begin
                r_item_valid <= 1'b1;
            end else if (res_load) begin
                r_item_valid <= 1'b0;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (item_load) begin
            r_item <= i_in_data;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

endmodule

### tb/tb_stick_auto_repeat_cursor_stepper_unit.sv
// self-checking testbench for stick_auto_repeat_cursor_stepper_unit
// holds a scoreboard class that predicts each frame's result; needs only sarcs_pkg and the rtl
`timescale 1ns / 1ps

import sarcs_pkg::*;

class stepper_scoreboard;
    localparam int MAX_REPORTS = 10;

    t_cfg      regs;
    t_hist     hist;
    t_out_item pending_steps[$];
    logic [7:0] last_cursor;
    int        mismatches;
    int        checked;

    function new();
        regs        = '{DEAD_ZONE_RST, REPEAT_DELAY_RST, REPEAT_PERIOD_RST};
        hist        = '0;
        last_cursor = '0;
        mismatches  = 0;
        checked     = 0;
    endfunction

    function int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function int pending();
        return pending_steps.size();
    endfunction

    function void write_reg(t_cfg_idx idx, logic [6:0] val);
        case (idx)
            CFG_DEAD_ZONE:     regs.dead_zone     = val;
            CFG_REPEAT_DELAY:  regs.repeat_delay  = val;
            CFG_REPEAT_PERIOD: regs.repeat_period = val;
            default: ;
        endcase
    endfunction

    // advance the hold counter for one accepted frame and queue its result
    function void note_frame(t_in_item f);
        int        dz, dly, per, sx, sy, px, py, cnt, cur, cmax, dir;
        bit        fire;
        t_out_item r;
        dz   = regs.dead_zone;
        dly  = (regs.repeat_delay == 0) ? 1 : regs.repeat_delay;
        per  = regs.repeat_period;
        sx   = $signed(f.stick_x);
        sy   = $signed(f.stick_y);
        px   = $signed(hist.previous_x);
        py   = $signed(hist.previous_y);
        cmax = f.cursor_max;
        if (magnitude(sx) > dz || magnitude(sy) > dz) begin
            cnt = hist.hold_counter;
            cnt = cnt + 1;
            // reversal only counts when the old sample was itself deflected
            if (sx * px < 0 && magnitude(px) > dz) cnt = 0;
            if (sy * py < 0 && magnitude(py) > dz) cnt = 0;
        end else begin
            cnt = 0;
        end
        if (cnt >= dly + per) cnt = dly - 1;
        hist.hold_counter = cnt[7:0];
        hist.previous_x   = f.stick_x;
        hist.previous_y   = f.stick_y;
        cnt  = hist.hold_counter;
        fire = 1'b0;
        dir  = 0;
        case (f.op) inside
            OP_X_AXIS: begin
                fire = (cnt == 1) || (cnt == dly);
                dir  = (sx > dz) ? 1 : (sx < -dz) ? -1 : 0;
            end
            OP_Y_STD, OP_Y_FAST, OP_Y_EXTRA: begin
                // y is inverted: pushing up moves the cursor down
                dir = (sy > dz) ? -1 : (sy < -dz) ? 1 : 0;
                if (f.op == OP_Y_STD)
                    fire = (cnt == 1) || (cnt == dly);
                else if (f.op == OP_Y_FAST)
                    fire = (cnt == 1) || (cnt >= dly - 1);
                else
                    fire = (cnt == 1) || (cnt == dly) || (cnt == dly + int'(EXTRA_REPEAT_OFS));
            end
            default: ;
        endcase
        cur = f.cursor_in;
        if (fire) begin
            cur = cur + dir;
            if (f.wrap) begin
                if (cur < 0) cur = cmax;
                if (cur > cmax) cur = 0;
            end else begin
                if (cur < 0) cur = 0;
                if (cur > cmax) cur = cmax;
            end
        end
        r.cursor_out = cur[7:0];
        r.hold_count = cnt[7:0];
        r.stepped    = fire;
        last_cursor  = r.cursor_out;
        pending_steps.push_back(r);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        checked++;
        if (pending_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d with nothing expected: cursor=%0d hold=%0d stepped=%0d",
                         checked, got.cursor_out, got.hold_count, got.stepped);
            return;
        end
        want = pending_steps.pop_front();
        if (got.cursor_out !== want.cursor_out || got.hold_count !== want.hold_count ||
            got.stepped !== want.stepped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"result %0d mismatch: expected cursor=%0d hold=%0d stepped=%0d, ",
                          "got cursor=%0d hold=%0d stepped=%0d"}, checked, want.cursor_out,
                         want.hold_count, want.stepped, got.cursor_out, got.hold_count,
                         got.stepped);
        end
    endfunction
endclass

module tb_stick_auto_repeat_cursor_stepper_unit;

    localparam int HALF_PERIOD    = 5;
    localparam int RANDOM_FRAMES  = 450;
    localparam int NUM_PHASES     = 6;
    localparam int LONG_HOLD      = 150;   // receiver hold-off that backs up the block
    localparam int WATCHDOG_LIMIT = 1500;  // cycles without any transfer
    localparam int END_CYCLES     = 8;     // two-stage pipe, plus margin

    // index 3 decodes to nothing; written once with each programmed setting to show it is ignored
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_DEAD_ZONE;
    logic [6:0] i_cfg_data  = '0;

    stepper_scoreboard sb = new();

    // shared between stimulus and the result sink
    int quiet_left [2] = '{0, 0};  // 0 = sender, 1 = receiver
    bit long_hold_req  = 1'b0;
    int frames_sent    = 0;
    int settings_used  = 1;        // reset values count as the first setting
    int idle_cycles    = 0;
    int in_stall_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    stick_auto_repeat_cursor_stepper_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // per-item random wait, with occasional stretches of back-to-back items
    function automatic int draw_wait(int side);
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) quiet_left[side] = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    function automatic t_in_item make_frame(t_op op, int sx, int sy, int cur, int cmax,
                                            bit wrap);
        t_in_item f;
        f.op         = op;
        f.stick_x    = sx[7:0];
        f.stick_y    = sy[7:0];
        f.cursor_in  = cur[7:0];
        f.cursor_max = cmax[7:0];
        f.wrap       = wrap;
        return f;
    endfunction

    // stick sample for one axis: dir 0 stays inside the dead zone, +1/-1 deflects (+1 cannot when dz is 127)
    function automatic logic [7:0] stick_sample(int dir, int dz);
        int m;
        if (dir == 0)
            m = int'($urandom_range(0, 2 * dz)) - dz;
        else if (dir > 0)
            m = (dz >= 127) ? 127 : int'($urandom_range(dz + 1, 127));
        else
            m = -int'($urandom_range(dz + 1, 128));
        return m[7:0];
    endfunction

    // offer one frame after a random gap and hold it until the transfer happens
    task automatic send_frame(t_in_item f);
        int gap;
        gap = draw_wait(0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_frame(f);
        frames_sent++;
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // all three registers back to back, then the ignored index
    task automatic program_regs(logic [6:0] dz, logic [6:0] dly, logic [6:0] per);
        t_cfg_idx   idx [4];
        logic [6:0] val [4];
        idx = '{CFG_DEAD_ZONE, CFG_REPEAT_DELAY, CFG_REPEAT_PERIOD, CFG_UNUSED};
        val = '{dz, dly, per, 7'($urandom_range(0, 127))};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly held-stick runs with the cursor fed back, plus releases and noise
    task automatic run_random_phase(int count, int dz, bit with_hold_off);
        int         sent, kind, run_len, dir_x, dir_y;
        t_op        run_op;
        logic [7:0] run_max;
        bit         run_wrap;
        t_in_item   f;
        sent = 0;
        while (sent < count) begin
            kind    = $urandom_range(0, 99);
            run_len = (kind < 70) ? $urandom_range(1, 30) : $urandom_range(1, 5);
            dir_x   = int'($urandom_range(0, 2)) - 1;
            dir_y   = int'($urandom_range(0, 2)) - 1;
            if (dir_x == 0 && dir_y == 0) dir_x = 1;
            run_op  = t_op'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0:       run_max = 8'd255;
                1:       run_max = 8'($urandom_range(0, 15));
                default: run_max = 8'($urandom_range(0, 255));
            endcase
            run_wrap = 1'($urandom_range(0, 1));
            for (int k = 0; k < run_len && sent < count; k++) begin
                f.op         = ($urandom_range(0, 9) == 0) ? t_op'($urandom_range(0, 7)) : run_op;
                f.cursor_max = run_max;
                f.wrap       = run_wrap;
                f.cursor_in  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.last_cursor;
                if (kind < 70) begin
                    // held direction, with the odd wild sample mixed in
                    f.stick_x = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : stick_sample(dir_x, dz);
                    f.stick_y = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : stick_sample(dir_y, dz);
                end else if (kind < 85) begin
                    f.stick_x = stick_sample(0, dz);
                    f.stick_y = stick_sample(0, dz);
                end else begin
                    f.op         = t_op'($urandom_range(0, 7));
                    f.stick_x    = 8'($urandom);
                    f.stick_y    = 8'($urandom);
                    f.cursor_in  = 8'($urandom);
                    f.cursor_max = 8'($urandom);
                    f.wrap       = 1'($urandom_range(0, 1));
                end
                if (with_hold_off && sent == count / 2) begin
                    // receiver goes quiet while the sender keeps pushing
                    long_hold_req = 1'b1;
                    quiet_left[0] = 40;
                end
                send_frame(f);
                sent++;
            end
        end
    endtask

    // result sink: random stall before each result, one long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                n = LONG_HOLD;
            end else begin
                n = draw_wait(1);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && i_rst_n)) @(posedge i_clk);
        end
    end

    // every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // watchdog: any transfer on any channel resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_in_valid && o_in_stall) in_stall_cycles <= in_stall_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int         directed_frames;
        logic [6:0] cfg_dz, cfg_dly, cfg_per;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings (dead zone 12, delay 9, period 2)
        send_frame(make_frame(OP_X_AXIS, 0, 0, 0, 255, 1'b0));  // released
        // full deflection on both axes: counts up through the delay and the reload,
        // all op codes, cursor and max at their extremes
        for (int i = 0; i < 14; i++)
            send_frame(make_frame(t_op'(i % 8), -128, 127, (i % 2) ? 255 : 0,
                                  (i % 4 >= 2) ? 0 : 255, i[0]));

        // lowered limit: counter already past delay + period, next frame reloads
        drain_results();
        program_regs(7'd12, 7'd2, 7'd1);
        send_frame(make_frame(OP_Y_STD, -128, 127, 128, 255, 1'b0));
        // x reverses from a deflected sample, counter clears
        send_frame(make_frame(OP_X_AXIS, 127, 127, 255, 255, 1'b1));
        // fire with y inside the dead zone, cursor already beyond max: wrap then clamp
        send_frame(make_frame(OP_Y_STD, 127, 5, 200, 100, 1'b1));
        send_frame(make_frame(OP_Y_FAST, 127, 5, 200, 100, 1'b0));
        // y flips sign from an undeflected sample, no clear; step above max wraps to 0
        send_frame(make_frame(OP_Y_EXTRA, 127, -128, 0, 0, 1'b1));
        // no-cursor op and an unused op code
        send_frame(make_frame(OP_NONE, 3, -3, 77, 50, 1'b0));
        send_frame(make_frame(t_op'(7), -128, 0, 255, 255, 1'b1));

        // zero delay behaves as one, zero dead zone, widest period
        drain_results();
        program_regs(7'd0, 7'd0, 7'd127);
        send_frame(make_frame(OP_X_AXIS, 1, 0, 255, 255, 1'b1));
        send_frame(make_frame(OP_X_AXIS, 1, 0, 255, 255, 1'b1));
        send_frame(make_frame(OP_Y_FAST, 1, -1, 0, 255, 1'b0));
        directed_frames = frames_sent;

        // random part: reset values, both extremes, then random settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: {cfg_dz, cfg_dly, cfg_per} = {DEAD_ZONE_RST, REPEAT_DELAY_RST,
                                                 REPEAT_PERIOD_RST};
                1: {cfg_dz, cfg_dly, cfg_per} = {7'd127, 7'd127, 7'd127};
                2: {cfg_dz, cfg_dly, cfg_per} = {7'd0, 7'd0, 7'd0};
                5: begin
                    cfg_dz  = 7'($urandom_range(0, 127));
                    cfg_dly = 7'($urandom_range(0, 127));
                    cfg_per = 7'($urandom_range(0, 127));
                end
                default: begin
                    // short delay and period so repeats happen often
                    cfg_dz  = 7'($urandom_range(0, 40));
                    cfg_dly = 7'($urandom_range(0, 8));
                    cfg_per = 7'($urandom_range(0, 6));
                end
            endcase
            drain_results();
            program_regs(cfg_dz, cfg_dly, cfg_per);
            run_random_phase(RANDOM_FRAMES / NUM_PHASES, cfg_dz, ph == 3);
        end

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("covered %0d frames (%0d directed) over %0d register settings, all op codes",
                 frames_sent, directed_frames, settings_used);
        $display("%0d results checked, %0d cycles of input back-pressure, %0d mismatches",
                 sb.checked, in_stall_cycles, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### stick_auto_repeat_cursor_stepper_unit.f
src/sarcs_pkg.sv
src/sarcs_step.sv
src/stick_auto_repeat_cursor_stepper_unit.sv
tb/tb_stick_auto_repeat_cursor_stepper_unit.sv
